// ===== design/odq_pkg.sv =====
// Shared constants and types for the ordered dither quantizer.
// No dependencies; the other design files refer to it by scoped names.
package odq_pkg;

    // Default values for the top-level parameters.
    localparam int MAX_MATRIX_LOG2_DEF = 4;
    localparam int COORD_BITS_DEF      = 12;

    // Fixed field widths.
    localparam int PIXEL_W  = 8;
    localparam int LEVEL_W  = 8;
    localparam int MLOG_W   = 3;
    localparam int LEVELS_W = 9;
    localparam int PROD_W   = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVELS      = 2'd1;

    localparam logic [MLOG_W-1:0]   MLOG_RESET   = 3'd2;
    localparam logic [LEVELS_W-1:0] LEVELS_RESET = 9'd2;

    // Full-scale pixel value; the fraction is counted in steps of 1/255.
    localparam logic [PIXEL_W-1:0] FULL_SCALE = 8'd255;

    // Per-item control flags that travel down the pipeline.
    typedef struct packed {
        logic zero_lvl;   // fewer than two levels: result is level 0
        logic zero_thr;   // threshold is zero: any nonzero fraction rounds up
    } odq_ctl_t;

endpackage

// ===== design/odq_bayer.sv =====
// Bayer matrix entry generator: interleaves the low coordinate bits.
// Depends on odq_pkg for the matrix size field width.
module odq_bayer #(
    parameter int MAX_LOG2   = odq_pkg::MAX_MATRIX_LOG2_DEF,
    parameter int COORD_BITS = odq_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0]          col,
    input  logic [COORD_BITS-1:0]          row,
    input  logic [odq_pkg::MLOG_W-1:0]     mlog,
    output logic [2*MAX_LOG2-1:0]          entry
);
    localparam int MW = 2 * MAX_LOG2;

    logic [MAX_LOG2-1:0] xb;
    logic [MAX_LOG2-1:0] yb;
    logic [MW-1:0]       full;
    logic [4:0]          rsh;

    // Coordinate bits above the coordinate width read as zero.
    for (genvar i = 0; i < MAX_LOG2; i++) begin : g_bits
        if (i < COORD_BITS) begin : g_in
            assign xb[i] = col[i];
            assign yb[i] = row[i];
        end else begin : g_zero
            assign xb[i] = 1'b0;
            assign yb[i] = 1'b0;
        end
    end

    // Place each bit pair as for the largest matrix, then shift down to size.
    always_comb begin
        full = '0;
        for (int i = 0; i < MAX_LOG2; i++) begin
            if (4'(i) < {1'b0, mlog}) begin
                full[2*(MAX_LOG2-1-i) +: 2] = {xb[i] ^ yb[i], yb[i]};
            end
        end
        rsh   = 5'(2 * MAX_LOG2) - {1'b0, mlog, 1'b0};
        entry = full >> rsh;
    end

endmodule

// ===== design/ordered_dither_quantizer.sv =====
// Ordered dither quantizer: four-stage pipeline, one beat accepted per cycle unless
// all stages are full and the output is stalled; throughput is one item per cycle,
// set by the single 8x8 multiplier and the divide-by-255 stages.
// A stalled output holds its beat; upstream stages keep filling empty slots.
// Synchronous active-low reset empties the pipeline and sets matrix_log2 to 2
// and levels to 2. Depends on odq_pkg and odq_bayer.
module ordered_dither_quantizer #(
    parameter int MAX_MATRIX_LOG2 = odq_pkg::MAX_MATRIX_LOG2_DEF,
    parameter int COORD_BITS      = odq_pkg::COORD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [odq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [odq_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [odq_pkg::PIXEL_W-1:0]       s_pixel,
    input  logic [COORD_BITS-1:0]             s_col,
    input  logic [COORD_BITS-1:0]             s_row,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [odq_pkg::LEVEL_W-1:0]       m_level
);
    localparam int MW = 2 * MAX_MATRIX_LOG2;   // matrix entry width
    localparam int CW = odq_pkg::PIXEL_W + MW; // threshold compare width
    localparam int SW = $clog2(MW + 1);        // shift amount width

    // Configuration registers.
    logic [odq_pkg::MLOG_W-1:0]   mlog_reg;
    logic [odq_pkg::LEVELS_W-1:0] levels_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mlog_reg   <= odq_pkg::MLOG_RESET;
            levels_reg <= odq_pkg::LEVELS_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                odq_pkg::REG_MATRIX_LOG2: mlog_reg <= cfg_data[odq_pkg::MLOG_W-1:0];
                odq_pkg::REG_LEVELS:      levels_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage occupancy and the ready chain; an empty stage can always take a beat.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Stage 1: step count, Bayer entry and control flags.
    logic [MW-1:0]                 entry;
    logic [odq_pkg::PIXEL_W-1:0]   steps_next;
    logic [SW-1:0]                 sh_next;
    odq_pkg::odq_ctl_t             ctl_next;

    odq_bayer #(
        .MAX_LOG2   (MAX_MATRIX_LOG2),
        .COORD_BITS (COORD_BITS)
    ) u_bayer (
        .col   (s_col),
        .row   (s_row),
        .mlog  (mlog_reg),
        .entry (entry)
    );

    always_comb begin
        ctl_next.zero_lvl = (levels_reg < 9'd2);
        ctl_next.zero_thr = (mlog_reg == '0) || (32'(mlog_reg) > MAX_MATRIX_LOG2);
        // Levels above 256 act as 256, so the step count saturates at 255.
        if (levels_reg >= 9'd256) begin
            steps_next = odq_pkg::FULL_SCALE;
        end else begin
            steps_next = levels_reg[7:0] - 8'd1;
        end
        sh_next = SW'({mlog_reg, 1'b0});
    end

    logic [odq_pkg::PIXEL_W-1:0]   pix1_reg;
    logic [odq_pkg::PIXEL_W-1:0]   steps1_reg;
    logic [MW-1:0]                 m1_reg;
    logic [SW-1:0]                 sh1_reg;
    odq_pkg::odq_ctl_t             ctl1_reg;

    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            pix1_reg   <= s_pixel;
            steps1_reg <= steps_next;
            m1_reg     <= entry;
            sh1_reg    <= sh_next;
            ctl1_reg   <= ctl_next;
        end
    end

    // Stage 2: scaled product and the threshold times 255.
    logic [odq_pkg::PROD_W-1:0]    prod2_reg;
    logic [CW-1:0]                 thr2_reg;
    logic [SW-1:0]                 sh2_reg;
    odq_pkg::odq_ctl_t             ctl2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            prod2_reg <= {8'd0, pix1_reg} * {8'd0, steps1_reg};
            thr2_reg  <= {m1_reg, 8'd0} - CW'(m1_reg);
            sh2_reg   <= sh1_reg;
            ctl2_reg  <= ctl1_reg;
        end
    end

    // Stage 3: quotient estimate by the reciprocal 257/65536, never above the
    // true quotient and at most one below it, and the matching remainder.
    logic [23:0]                   recip;
    logic [odq_pkg::LEVEL_W-1:0]   q0;
    logic [odq_pkg::PROD_W-1:0]    q0x255;
    logic [odq_pkg::PROD_W-1:0]    r0_full;

    always_comb begin
        recip   = {prod2_reg, 8'd0} + 24'(prod2_reg);
        q0      = recip[23:16];
        q0x255  = {q0, 8'd0} - 16'(q0);
        r0_full = prod2_reg - q0x255;
    end

    logic [odq_pkg::LEVEL_W-1:0]   q3_reg;
    logic [8:0]                    r3_reg;
    logic [CW-1:0]                 thr3_reg;
    logic [SW-1:0]                 sh3_reg;
    odq_pkg::odq_ctl_t             ctl3_reg;

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            q3_reg   <= q0;
            r3_reg   <= r0_full[8:0];
            thr3_reg <= thr2_reg;
            sh3_reg  <= sh2_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    // Stage 4: fix the quotient, compare the fraction with the threshold.
    logic                          fix;
    logic [odq_pkg::PIXEL_W-1:0]   rem;
    logic [odq_pkg::LEVEL_W-1:0]   quo;
    logic [CW-1:0]                 frac;
    logic                          up;
    logic [odq_pkg::LEVEL_W-1:0]   level_next;

    always_comb begin
        fix  = (r3_reg >= 9'd255);
        rem  = fix ? 8'(r3_reg - 9'd255) : r3_reg[7:0];
        quo  = q3_reg + 8'(fix);
        frac = CW'(rem) << sh3_reg;
        if (ctl3_reg.zero_thr) begin
            up = (rem != '0);
        end else begin
            up = (frac > thr3_reg);
        end
        level_next = ctl3_reg.zero_lvl ? '0 : quo + 8'(up);
    end

    logic [odq_pkg::LEVEL_W-1:0]   level4_reg;

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            level4_reg <= level_next;
        end
    end

    assign m_valid = v4_reg;
    assign m_level = level4_reg;

    // An accepted beat always lands in the first stage.
    a_accept_fills : assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v1_reg)
        else $error("accepted beat did not enter stage 1");

    // With every stage full and the output stalled, no beat may enter.
    a_full_stall : assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && v2_reg && v3_reg && v4_reg && !m_ready |-> !s_ready)
        else $error("input accepted into a full stalled pipeline");

    // The reciprocal estimate leaves a remainder below twice the divisor.
    a_rem_range : assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> r3_reg < 9'd510)
        else $error("divide-by-255 remainder out of range");

    // A stalled stage-4 beat is not overwritten by stage 3.
    a_no_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg && !m_ready |=> v4_reg && $stable(level4_reg))
        else $error("stalled result overwritten");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for ordered_dither_quantizer: random and directed pixel beats,
// a functional predictor of the dithered level, and a scoreboard on the result channel.
// Depends on odq_pkg and the ordered_dither_quantizer design files.
`timescale 1ns / 1ps

module tb;

    localparam int COORD_W      = odq_pkg::COORD_BITS_DEF;
    localparam int MAX_MLOG     = odq_pkg::MAX_MATRIX_LOG2_DEF;
    localparam int PIXEL_W      = odq_pkg::PIXEL_W;
    localparam int LEVEL_W      = odq_pkg::LEVEL_W;
    localparam int MLOG_W       = odq_pkg::MLOG_W;
    localparam int LEVELS_W     = odq_pkg::LEVELS_W;
    localparam int CFG_IDX_W    = odq_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = odq_pkg::CFG_DATA_W;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PRINT_LIMIT  = 40;
    localparam int NUM_SETTINGS = 16;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } pixel_beat_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [PIXEL_W-1:0]    s_pixel   = '0;
    logic [COORD_W-1:0]    s_col     = '0;
    logic [COORD_W-1:0]    s_row     = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [LEVEL_W-1:0]    m_level;

    // Shadow copy of the quantizer settings, updated when a write beat is taken.
    logic [MLOG_W-1:0]   mlog_cfg   = odq_pkg::MLOG_RESET;
    logic [LEVELS_W-1:0] levels_cfg = odq_pkg::LEVELS_RESET;

    pixel_beat_t        pixel_q[$];
    logic [LEVEL_W-1:0] expected_levels[$];
    pixel_beat_t        next_beat;
    logic [LEVEL_W-1:0] want_level;
    logic               gap_free  = 1'b0;
    logic               sink_hold = 1'b0;
    int                 items_accepted  = 0;
    int                 results_checked = 0;
    int                 mismatches      = 0;
    int                 idle_cycles     = 0;

    // Settings swept after the directed part: matrix_log2, levels, pixel beats.
    int unsigned sweep_mlog[NUM_SETTINGS] = '{0, 4, 1, 3, 4, 5, 7, 6, 2, 3, 1, 2, 4, 0, 3, 2};
    int unsigned sweep_levels[NUM_SETTINGS] =
        '{256, 256, 3, 17, 2, 100, 511, 257, 1, 0, 255, 129, 64, 2, 256, 5};
    int unsigned sweep_count[NUM_SETTINGS] =
        '{110, 130, 100, 110, 100, 60, 60, 50, 40, 40, 100, 110, 110, 60, 120, 125};

    ordered_dither_quantizer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .s_col     (s_col),
        .s_row     (s_row),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_level   (m_level)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Expected level: floor of pixel*(levels-1)/255 (levels capped at 256, level 0 below
    // two levels), plus one when the remainder beats the Bayer threshold at the low coordinate bits.
    function automatic logic [LEVEL_W-1:0] dither_level(input logic [PIXEL_W-1:0] pixel,
                                                         input logic [COORD_W-1:0] col,
                                                         input logic [COORD_W-1:0] row);
        int unsigned steps, prod, whole, frac, rank, n, i;
        logic        round_up;
        if (levels_cfg < 2) begin
            return '0;
        end
        steps = (levels_cfg > 256) ? 255 : int'(levels_cfg) - 1;
        prod  = pixel * steps;
        whole = prod / 255;
        frac  = prod % 255;
        if (mlog_cfg == 0 || mlog_cfg > MAX_MLOG) begin
            round_up = (frac != 0);
        end else begin
            // Bit-interleaved rank gives the standard recursive Bayer matrix.
            n    = 32'(mlog_cfg);
            rank = 0;
            for (i = 0; i < n; i++) begin
                rank |= 32'({col[i] ^ row[i], row[i]}) << (2 * (n - 1 - i));
            end
            round_up = (frac << (2 * n)) > rank * 255;
        end
        return LEVEL_W'(whole + round_up);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_LIMIT) begin
            $display("%0t ns: MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    task automatic queue_item(input int pixel, input int col, input int row);
        pixel_beat_t beat;
        beat.pixel = PIXEL_W'(pixel);
        beat.col   = COORD_W'(col);
        beat.row   = COORD_W'(row);
        pixel_q.push_back(beat);
    endtask

    task automatic queue_random(input int unsigned count);
        int unsigned k;
        int          pixel;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(7))
                0:       pixel = 0;
                1:       pixel = 255;
                default: pixel = $urandom_range(255);
            endcase
            queue_item(pixel, $urandom_range(4095), $urandom_range(4095));
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == odq_pkg::REG_MATRIX_LOG2) begin
            mlog_cfg = data[MLOG_W-1:0];
        end else if (idx == odq_pkg::REG_LEVELS) begin
            levels_cfg = data;
        end
    endtask

    // Every result returns one beat, so the block is idle once nothing is queued,
    // offered or outstanding. The check sits at the falling edge, after all
    // updates of the rising edge have settled.
    task automatic wait_idle();
        do @(negedge aclk);
        while (pixel_q.size() != 0 || s_valid || expected_levels.size() != 0);
    endtask

    // Input driver: takes beats from the pending queue and predicts on acceptance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_levels.push_back(dither_level(s_pixel, s_col, s_row));
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pixel_q.size() != 0 && (gap_free || $urandom_range(99) >= 31)) begin
                    next_beat = pixel_q.pop_front();
                    s_valid <= 1'b1;
                    s_pixel <= next_beat.pixel;
                    s_col   <= next_beat.col;
                    s_row   <= next_beat.row;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each level beat against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_levels.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding", m_level, -1);
                end else begin
                    want_level = expected_levels.pop_front();
                    results_checked++;
                    if (m_level !== want_level) begin
                        report_mismatch("level", m_level, want_level);
                    end
                end
            end
            m_ready <= !sink_hold && (gap_free || $urandom_range(99) >= 31);
        end
    end

    // Long receiver hold-off while the sender still has plenty queued,
    // so the pipeline fills and back-pressures the input.
    initial begin
        wait (items_accepted >= 300 && pixel_q.size() > 40);
        @(posedge aclk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        sink_hold <= 1'b0;
    end

    // Watchdog on cycles in which no beat moves on any channel.
    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
        $display("ordered_dither_quantizer verification failed");
        $finish;
    end

    // Main sequence: reset, directed beats at the reset settings, then a sweep
    // over quantizer settings with random beats.
    initial begin
        int k, ph;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Extremes of intensity and coordinates under the 4x4 matrix and two levels.
        queue_item(0, 0, 0);
        queue_item(255, 4095, 4095);
        queue_item(255, 0, 0);
        queue_item(0, 4095, 4095);
        queue_item(1, 0, 0);
        queue_item(1, 1, 1);
        queue_item(254, 4095, 0);
        queue_item(127, 2048, 1);
        queue_item(200, 1, 2048);
        queue_item(64, 'hAAA, 'h555);
        queue_item(191, 'h555, 'hAAA);
        // Mid-gray across every cell of the 4x4 matrix, with high bits varied.
        for (k = 0; k < 16; k++) begin
            queue_item(128, (k & 3) | (k << 4), (k >> 2) | (k << 6));
        end
        wait_idle();

        for (ph = 0; ph < NUM_SETTINGS; ph++) begin
            write_reg(odq_pkg::REG_MATRIX_LOG2, CFG_DATA_W'(sweep_mlog[ph]));
            write_reg(odq_pkg::REG_LEVELS, CFG_DATA_W'(sweep_levels[ph]));
            gap_free <= (ph >= 5 && ph <= 7);
            queue_random(sweep_count[ph]);
            wait_idle();
        end
        gap_free <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d pixel beats over %0d quantizer settings, matrix sizes off to 16x16,",
                 items_accepted, NUM_SETTINGS + 1);
        $display("levels 0 to 511, with a long output stall; %0d results checked, %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0 && expected_levels.size() == 0) begin
            $display("ordered_dither_quantizer verification clean");
        end else begin
            $display("ordered_dither_quantizer verification failed");
        end
        $finish;
    end

endmodule
